### design/lsf_pkg.sv
// ---------------------------------------------------------------------------
// lsf_pkg
// Shared types, constants and helpers of the line substring filter.
// ---------------------------------------------------------------------------
package lsf_pkg;

  localparam int MAX_PATTERN_DEF = 19;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int PAT_REG_BYTES   = 19;
  localparam int BYTE_W          = 8;
  localparam int OUT_W           = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int PAT_LEN_W       = 5;
  localparam int MODE_W          = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW  = 3'd0,
    CFG_PAT_MID  = 3'd1,
    CFG_PAT_HIGH = 3'd2,
    CFG_PAT_LEN  = 3'd3,
    CFG_MODE     = 3'd4
  } cfg_reg_e;

  typedef logic [PAT_REG_BYTES-1:0][BYTE_W-1:0] pat_bytes_t;

  typedef struct packed {
    pat_bytes_t           pattern;
    logic [PAT_LEN_W-1:0] pat_len;
    logic                 invert;
    logic                 nocase;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic matched;
  } line_evt_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic nocase);
    logic [BYTE_W-1:0] r;
    r = b;
    if (nocase && b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

### design/lsf_if.sv
// ---------------------------------------------------------------------------
// lsf_if
// Valid/ready channels of the line substring filter: text beats in,
// per-line result beats out.
// ---------------------------------------------------------------------------
interface lsf_in_if;
  import lsf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              line_end;

  modport source (output valid, text_byte, line_end, input ready);
  modport sink   (input valid, text_byte, line_end, output ready);
endinterface

interface lsf_out_if;
  import lsf_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] line_number;
  logic             line_selected;
  logic [OUT_W-1:0] selected_count;

  modport source (output valid, line_number, line_selected, selected_count, input ready);
  modport sink   (input valid, line_number, line_selected, selected_count, output ready);
endinterface

### design/lsf_cfg_regs.sv
// ---------------------------------------------------------------------------
// lsf_cfg_regs
// Configuration register file: pattern bytes, pattern length, match mode.
// ---------------------------------------------------------------------------
module lsf_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lsf_pkg::cfg_t                  cfg
);
  import lsf_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAT_LOW:  cfg_r.pattern[7:0]   <= cfg_wdata;
        CFG_PAT_MID:  cfg_r.pattern[15:8]  <= cfg_wdata;
        CFG_PAT_HIGH: cfg_r.pattern[18:16] <= cfg_wdata[3*BYTE_W-1:0];
        CFG_PAT_LEN:  cfg_r.pat_len        <= cfg_wdata[PAT_LEN_W-1:0];
        CFG_MODE: begin
          cfg_r.nocase <= cfg_wdata[0];
          cfg_r.invert <= cfg_wdata[1];
        end
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### design/lsf_matcher.sv
// ---------------------------------------------------------------------------
// lsf_matcher
// Input register, in-line byte window and parallel window/pattern compare.
// Raises one line event per line-end beat.
// ---------------------------------------------------------------------------
module lsf_matcher #(
  parameter int MAX_PATTERN = lsf_pkg::MAX_PATTERN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  lsf_in_if.sink             in_ch,
  input  lsf_pkg::cfg_t      cfg,
  input  logic               slot_free,
  output lsf_pkg::line_evt_t evt
);
  import lsf_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_r, window_nxt, win_new;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_ext;
  logic [LEN_W-1:0]                   bil_r, bil_nxt, bil_new;
  logic                               flag_r, flag_nxt;

  logic [LEN_W-1:0] len;
  logic [IDX_W-1:0] w_idx;
  logic             all_eq;
  logic             hit;
  logic             advance;

  assign advance     = s1_valid_r && (!s1_last_r || slot_free);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.text_byte;
      s1_last_r <= in_ch.line_end;
    end
  end

  always_comb begin
    len = (cfg.pat_len > PAT_LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                   : LEN_W'(cfg.pat_len);
    win_new[0] = s1_byte_r;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_new[j] = window_r[j-1];
    end
    bil_new = (bil_r == LEN_W'(MAX_PATTERN)) ? bil_r : bil_r + 1'b1;
  end

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (k < PAT_REG_BYTES) begin
        pat_ext[k] = cfg.pattern[k];
      end else begin
        pat_ext[k] = '0;
      end
    end
  end

  always_comb begin
    all_eq = 1'b1;
    w_idx  = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (k < int'(len)) begin
        w_idx = IDX_W'(int'(len) - 1 - k);
        if (fold_byte(win_new[w_idx], cfg.nocase) != fold_byte(pat_ext[k], cfg.nocase)) begin
          all_eq = 1'b0;
        end
      end
    end
    hit = (len == '0) || ((bil_new >= len) && all_eq);
  end

  always_comb begin
    window_nxt = window_r;
    bil_nxt    = bil_r;
    flag_nxt   = flag_r;
    if (advance) begin
      if (s1_last_r) begin
        window_nxt = '0;
        bil_nxt    = '0;
        flag_nxt   = 1'b0;
      end else begin
        window_nxt = win_new;
        bil_nxt    = bil_new;
        flag_nxt   = flag_r || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      bil_r    <= '0;
      flag_r   <= 1'b0;
    end else begin
      window_r <= window_nxt;
      bil_r    <= bil_nxt;
      flag_r   <= flag_nxt;
    end
  end

  assign evt.valid   = advance && s1_last_r;
  assign evt.matched = flag_r || hit;

endmodule

### design/lsf_result.sv
// ---------------------------------------------------------------------------
// lsf_result
// Saturating line and selection counters plus the result output register.
// ---------------------------------------------------------------------------
module lsf_result #(
  parameter int COUNT_BITS = lsf_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lsf_pkg::line_evt_t evt,
  input  logic               invert,
  output logic               slot_free,
  lsf_out_if.source          out_ch
);
  import lsf_pkg::*;

  logic [COUNT_BITS-1:0] line_cnt_r, line_cnt_nxt;
  logic [COUNT_BITS-1:0] sel_cnt_r, sel_cnt_nxt;
  logic                  out_valid_r;
  logic                  sel_r;
  logic                  sel;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign sel       = evt.matched ^ invert;

  always_comb begin
    line_cnt_nxt = line_cnt_r;
    sel_cnt_nxt  = sel_cnt_r;
    if (evt.valid) begin
      line_cnt_nxt = (&line_cnt_r) ? line_cnt_r : line_cnt_r + 1'b1;
      if (sel) begin
        sel_cnt_nxt = (&sel_cnt_r) ? sel_cnt_r : sel_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r  <= '0;
      sel_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      line_cnt_r <= line_cnt_nxt;
      sel_cnt_r  <= sel_cnt_nxt;
      if (evt.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid) begin
      sel_r <= sel;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.line_number    = OUT_W'(line_cnt_r);
  assign out_ch.line_selected  = sel_r;
  assign out_ch.selected_count = OUT_W'(sel_cnt_r);

  a_evt_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    evt.valid |-> slot_free)
    else $error("line event while result slot busy");

  a_evt_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    evt.valid |=> out_valid_r)
    else $error("line event did not load result register");

  a_sel_le_line: assert property (@(posedge clk) disable iff (!rst_n)
    sel_cnt_r <= line_cnt_r)
    else $error("selected count exceeds line count");

  a_line_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (evt.valid && !(&line_cnt_r)) |=> (line_cnt_r == $past(line_cnt_r) + 1'b1))
    else $error("line counter did not advance");

  a_cnt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !evt.valid |=> $stable(line_cnt_r) && $stable(sel_cnt_r))
    else $error("counter moved without a line event");

endmodule

### design/line_substring_filter_unit.sv
// ---------------------------------------------------------------------------
// line_substring_filter_unit
// Fixed-string line filter: flags lines with (or, inverted, without) the pattern.
// ---------------------------------------------------------------------------
// Takes one text byte per cycle, with no bubbles between lines, while the
// input is not back-pressured. Each byte is registered, then compared against
// the configured pattern through a fully parallel window comparator, one byte
// compare per pattern position; a line-end beat passes the input register and
// then the result register. Input back-pressure occurs only while a finished
// result is held and the next line end is ready to go. Configure only while no
// line-end beat is in flight.
module line_substring_filter_unit #(
  parameter int MAX_PATTERN = lsf_pkg::MAX_PATTERN_DEF,
  parameter int COUNT_BITS  = lsf_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lsf_in_if.sink                         in_ch,
  lsf_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lsf_pkg::*;

  cfg_t      cfg;
  line_evt_t evt;
  logic      slot_free;

  lsf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lsf_matcher #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_matcher (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .slot_free (slot_free),
    .evt       (evt)
  );

  lsf_result #(
    .COUNT_BITS (COUNT_BITS)
  ) u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt       (evt),
    .invert    (cfg.invert),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

endmodule
